// ===== rtl/pqs_pkg.sv =====
// Package for the priority quantum scheduler.
// Holds request codes, state encodings and fixed field widths.
// No dependencies.
package pqs_pkg;

   localparam int unsigned TypeBits     = 2;
   localparam int unsigned IndexBits    = 4;
   localparam int unsigned ArrivalBits  = 16;
   localparam int unsigned DurBits      = 8;
   localparam int unsigned PrioBits     = 8;
   localparam int unsigned StatBits     = 16;
   localparam int unsigned QuantumBits  = 8;
   localparam int unsigned ActiveBits   = 5;
   localparam int unsigned CsrAddrBits  = 1;
   localparam int unsigned CsrDataBits  = 8;
   localparam logic [QuantumBits-1:0] QuantumReset = 8'd2;

   typedef enum logic [TypeBits-1:0] {
      REQ_LOAD = 2'd0,
      REQ_TICK = 2'd1,
      REQ_READ = 2'd2,
      REQ_NONE = 2'd3
   } req_kind_type;

   typedef enum logic [CsrAddrBits-1:0] {
      CSR_QUANTUM = 1'd0,
      CSR_ACTIVE  = 1'd1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_UPDATE,
      ST_READ,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic [TypeBits-1:0]    req_type;
      logic [IndexBits-1:0]   entry_index;
      logic [ArrivalBits-1:0] arrival_time;
      logic [DurBits-1:0]     service_duration;
      logic [PrioBits-1:0]    priority_level;
   } req_word_type;

   typedef struct packed {
      logic [IndexBits-1:0] running_index;
      logic                 running_valid;
      logic                 all_finished;
      logic [15:0]          tick_number;
      logic [StatBits-1:0]  stat_total_time;
      logic [StatBits-1:0]  stat_life_time;
      logic [StatBits-1:0]  stat_alternations;
      logic                 stat_finished;
   } rsp_word_type;

endpackage

// ===== rtl/pqs_req_if.sv =====
// Valid/ready channel interfaces for request and response words.
// Depends on pqs_pkg.
interface pqs_req_if;
   logic                  valid;
   logic                  ready;
   pqs_pkg::req_word_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface pqs_rsp_if;
   logic                  valid;
   logic                  ready;
   pqs_pkg::rsp_word_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/priority_quantum_scheduler_core.sv =====
// Top level of the priority quantum scheduler.
// Depends on pqs_pkg and the channel interfaces in pqs_req_if.sv.
//
// Usage: request words arrive on req (valid/ready); each gives one response
// word on rsp. A load writes one table entry and clears its statistics, a
// tick advances time and reschedules, a read returns one entry's statistics.
// csr_write_enable / csr_index / csr_write_data set quantum (index 0) and
// active_entries (index 1); write them only while idle.
// Flow: a load is answered from ST_DECIDE, a read from ST_OUT after the
// entry memory read in ST_READ. A tick scans the active entries (one table
// entry read per cycle from the entry memory), picks the task in the first
// update step and then runs an update pass (one read-modify-write per
// cycle over the whole table) before it answers. One word is in work at a
// time; with rsp.ready high the next word can be taken in the cycle the
// response appears.
// The response sits in an output register and holds until rsp.ready; no
// new request is accepted until the waiting response leaves.
// Reset (synchronous, active high) clears control state, the valid bits of
// the statistics, time, the running task and loads quantum = 2.
// Statistics are kept in one memory, tables in another; both have a
// registered read port.
module priority_quantum_scheduler_core #(
   parameter int unsigned NUM_ENTRIES = 16,
   parameter int unsigned TIME_BITS   = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   pqs_req_if.sink                          req,
   pqs_rsp_if.source                        rsp,
   input  logic                             csr_write_enable,
   input  logic [pqs_pkg::CsrAddrBits-1:0]  csr_index,
   input  logic [pqs_pkg::CsrDataBits-1:0]  csr_write_data
);

   localparam int unsigned EB = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
   localparam int unsigned CB = $clog2(NUM_ENTRIES + 1);
   localparam logic [CB-1:0] NumLim = CB'(NUM_ENTRIES);
   localparam logic [TIME_BITS-1:0] TimeMax = {TIME_BITS{1'b1}};
   localparam logic [15:0] StatMax = 16'hFFFF;
   localparam logic [7:0]  ByteMax = 8'hFF;

   typedef struct packed {
      logic [pqs_pkg::ArrivalBits-1:0] arrival;
      logic [pqs_pkg::DurBits-1:0]     duration;
      logic [pqs_pkg::PrioBits-1:0]    prio;
   } task_type;

   typedef struct packed {
      logic [7:0]  served;
      logic [15:0] life;
      logic [15:0] present;
      logic [15:0] switches;
      logic        done;
   } stat_type;

   // memories
   task_type task_mem [NUM_ENTRIES];
   stat_type stat_mem [NUM_ENTRIES];
   logic [NUM_ENTRIES-1:0] stat_valid_ff;

   pqs_pkg::state_type state_ff, state_in;
   pqs_pkg::req_word_type word_ff;
   logic [7:0]  quantum_ff;
   logic [4:0]  active_ff;
   logic [EB-1:0] cur_task_ff, cur_task_in;
   logic cur_valid_ff, cur_valid_in;
   logic [7:0] slice_ff, slice_in;
   logic [TIME_BITS-1:0] time_ff, time_in;
   logic [CB-1:0] cnt_ff, cnt_in;
   logic phase_ff, phase_in;           // update state: 0 = pick, 1 = update pass
   logic found_ff, found_in;
   logic [EB-1:0] best_ff, best_in;
   logic [7:0] best_prio_ff, best_prio_in;
   logic run_ok_ff, run_ok_in;
   logic all_done_ff, all_done_in;
   logic rd_valid_ff;
   logic [EB-1:0] rd_idx_ff;
   task_type task_rd_ff;
   stat_type stat_rd_raw_ff;
   pqs_pkg::rsp_word_type out_ff, out_in;
   logic out_valid_ff, out_valid_in;

   // memory port control
   logic [EB-1:0] rd_addr;
   logic rd_en;
   logic st_we;
   logic [EB-1:0] st_waddr;
   stat_type st_wdata;
   logic tk_we;

   logic [CB-1:0] n_lim;
   logic idx_ok;
   stat_type stat_rd;
   logic elig_rd;

   assign n_lim = (32'(active_ff) > NUM_ENTRIES) ? NumLim : CB'(active_ff);
   assign idx_ok = (32'(word_ff.entry_index) < NUM_ENTRIES);
   assign stat_rd = rd_valid_ff ? stat_rd_raw_ff : '0;
   assign elig_rd = ({1'b0, rd_idx_ff} < {1'b0, n_lim}) && !stat_rd.done &&
                    (32'(task_rd_ff.arrival) <= 32'(time_ff));

   assign req.ready = (state_ff == pqs_pkg::ST_IDLE) && (!out_valid_ff || rsp.ready);
   assign rsp.valid = out_valid_ff;
   assign rsp.data  = out_ff;

   // memories: one read port, one write port each
   always_ff @(posedge clock) begin
      if (tk_we) begin
         task_mem[EB'(word_ff.entry_index)] <=
            '{word_ff.arrival_time, word_ff.service_duration, word_ff.priority_level};
      end
      if (st_we) begin
         stat_mem[st_waddr] <= st_wdata;
      end
      if (rd_en) begin
         task_rd_ff     <= task_mem[rd_addr];
         stat_rd_raw_ff <= stat_mem[rd_addr];
         rd_idx_ff      <= rd_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stat_valid_ff <= '0;
         rd_valid_ff   <= 1'b0;
      end else begin
         if (st_we) begin
            stat_valid_ff[st_waddr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= stat_valid_ff[rd_addr] && !(st_we && st_waddr == rd_addr);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pqs_pkg::ST_IDLE;
         quantum_ff   <= pqs_pkg::QuantumReset;
         active_ff    <= '0;
         cur_task_ff  <= '0;
         cur_valid_ff <= 1'b0;
         slice_ff     <= pqs_pkg::QuantumReset;
         time_ff      <= '0;
         out_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         phase_ff     <= 1'b0;
         found_ff     <= 1'b0;
         run_ok_ff    <= 1'b0;
         all_done_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_task_ff  <= cur_task_in;
         cur_valid_ff <= cur_valid_in;
         slice_ff     <= slice_in;
         time_ff      <= time_in;
         out_valid_ff <= out_valid_in;
         cnt_ff       <= cnt_in;
         phase_ff     <= phase_in;
         found_ff     <= found_in;
         run_ok_ff    <= run_ok_in;
         all_done_ff  <= all_done_in;
         if (csr_write_enable) begin
            case (pqs_pkg::csr_index_type'(csr_index))
               pqs_pkg::CSR_QUANTUM: quantum_ff <= csr_write_data;
               pqs_pkg::CSR_ACTIVE:  active_ff  <= csr_write_data[4:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         word_ff <= req.data;
      end
      best_ff      <= best_in;
      best_prio_ff <= best_prio_in;
      out_ff       <= out_in;
   end

   // sequencer: scan phase reads entries 0..n-1 and tracks the best
   // candidate and whether the running task is still eligible; update
   // phase reads every table entry again and writes back its charged
   // statistics, so a task left from outside the active range still gets
   // its alternation.
   always_comb begin
      state_in     = state_ff;
      cur_task_in  = cur_task_ff;
      cur_valid_in = cur_valid_ff;
      slice_in     = slice_ff;
      time_in      = time_ff;
      out_valid_in = out_valid_ff && !rsp.ready;
      out_in       = out_ff;
      cnt_in       = cnt_ff;
      phase_in     = phase_ff;
      found_in     = found_ff;
      best_in      = best_ff;
      best_prio_in = best_prio_ff;
      run_ok_in    = run_ok_ff;
      all_done_in  = all_done_ff;
      rd_en        = 1'b0;
      rd_addr      = '0;
      st_we        = 1'b0;
      st_waddr     = EB'(word_ff.entry_index);
      st_wdata     = '0;
      tk_we        = 1'b0;

      case (state_ff)
         pqs_pkg::ST_IDLE: begin
            if (req.valid && req.ready) begin
               case (pqs_pkg::req_kind_type'(req.data.req_type))
                  pqs_pkg::REQ_TICK: begin
                     state_in  = pqs_pkg::ST_SCAN;
                     cnt_in    = '0;
                     phase_in  = 1'b0;
                     found_in  = 1'b0;
                     run_ok_in = 1'b0;
                  end
                  pqs_pkg::REQ_READ: state_in = pqs_pkg::ST_READ;
                  default:           state_in = pqs_pkg::ST_DECIDE;
               endcase
            end
         end
         pqs_pkg::ST_DECIDE: begin
            // load or unused code: a load with a valid index writes its entry; both finish
            if (pqs_pkg::req_kind_type'(word_ff.req_type) == pqs_pkg::REQ_LOAD && idx_ok) begin
               tk_we = 1'b1;
               st_we = 1'b1;
            end
            out_in       = '0;
            out_valid_in = 1'b1;
            state_in     = pqs_pkg::ST_IDLE;
         end
         pqs_pkg::ST_READ: begin
            rd_en    = 1'b1;
            rd_addr  = EB'(word_ff.entry_index);
            state_in = pqs_pkg::ST_OUT;
         end
         pqs_pkg::ST_OUT: begin
            out_in = '0;
            if (idx_ok) begin
               out_in.stat_total_time   = stat_rd.present;
               out_in.stat_life_time    = stat_rd.life;
               out_in.stat_alternations = stat_rd.switches;
               out_in.stat_finished     = stat_rd.done;
            end
            out_valid_in = 1'b1;
            state_in     = pqs_pkg::ST_IDLE;
         end
         pqs_pkg::ST_SCAN: begin
            // issue read of entry cnt, evaluate entry cnt-1
            if (cnt_ff < n_lim) begin
               rd_en   = 1'b1;
               rd_addr = cnt_ff[EB-1:0];
            end
            if (cnt_ff != '0) begin
               if (elig_rd && cur_valid_ff && rd_idx_ff == cur_task_ff) begin
                  run_ok_in = 1'b1;
               end else if (elig_rd &&
                            (!found_ff || task_rd_ff.prio < best_prio_ff)) begin
                  found_in     = 1'b1;
                  best_in      = rd_idx_ff;
                  best_prio_in = task_rd_ff.prio;
               end
            end
            if (cnt_ff >= n_lim) begin
               state_in = pqs_pkg::ST_UPDATE;
               cnt_in   = '0;
               phase_in = 1'b0;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         pqs_pkg::ST_UPDATE: begin
            if (!phase_ff) begin
               // pick the task for this tick
               if (!run_ok_ff || slice_ff >= quantum_ff) begin
                  if (found_ff) begin
                     if (cur_valid_ff && best_ff != cur_task_ff) begin
                        // switch counted during update pass
                        run_ok_in = 1'b1;
                     end else begin
                        run_ok_in = 1'b0;
                     end
                     // remember task left in best, with best_prio as flag carrier
                     best_in      = cur_task_ff;
                     best_prio_in = {7'd0, cur_valid_ff && best_ff != cur_task_ff};
                     cur_task_in  = best_ff;
                     cur_valid_in = 1'b1;
                  end else begin
                     best_prio_in = 8'd0;
                     if (!run_ok_ff) begin
                        cur_valid_in = 1'b0;
                        cur_task_in  = '0;
                     end
                  end
                  slice_in = 8'd1;
               end else begin
                  best_prio_in = 8'd0;
                  slice_in = (slice_ff < ByteMax) ? slice_ff + 1'b1 : ByteMax;
               end
               all_done_in = 1'b1;
               phase_in    = 1'b1;
               cnt_in      = '0;
            end else begin
               if (cnt_ff < NumLim) begin
                  rd_en   = 1'b1;
                  rd_addr = cnt_ff[EB-1:0];
               end
               if (cnt_ff != '0) begin
                  st_we    = 1'b1;
                  st_waddr = rd_idx_ff;
                  st_wdata = stat_rd;
                  if (best_prio_ff[0] && rd_idx_ff == best_ff) begin
                     st_wdata.switches = (stat_rd.switches < StatMax) ?
                                         stat_rd.switches + 1'b1 : StatMax;
                  end
                  if (elig_rd) begin
                     if (cur_valid_ff && rd_idx_ff == cur_task_ff) begin
                        st_wdata.served = (stat_rd.served < ByteMax) ?
                                          stat_rd.served + 1'b1 : ByteMax;
                     end
                     st_wdata.present = (stat_rd.present < StatMax) ?
                                        stat_rd.present + 1'b1 : StatMax;
                     if (st_wdata.served != 8'd0) begin
                        st_wdata.life = (stat_rd.life < StatMax) ?
                                        stat_rd.life + 1'b1 : StatMax;
                     end
                     if (cur_valid_ff && rd_idx_ff == cur_task_ff &&
                         st_wdata.served >= task_rd_ff.duration) begin
                        st_wdata.done = 1'b1;
                     end
                  end
                  // only active entries count toward all_finished
                  if (!st_wdata.done && ({1'b0, rd_idx_ff} < {1'b0, n_lim})) begin
                     all_done_in = 1'b0;
                  end
               end
               if (cnt_ff >= NumLim) begin
                  out_in = '0;
                  out_in.running_index = cur_valid_ff ? 4'(cur_task_ff) : 4'd0;
                  out_in.running_valid = cur_valid_ff;
                  out_in.all_finished  = all_done_in;
                  out_in.tick_number   = 16'(time_ff);
                  out_valid_in         = 1'b1;
                  time_in  = (time_ff < TimeMax) ? time_ff + 1'b1 : TimeMax;
                  state_in = pqs_pkg::ST_IDLE;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
         end
         default: state_in = pqs_pkg::ST_IDLE;
      endcase
   end

   // assertions
   a_single_out: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> !req.ready)
      else $error("accepted word did not block the channel");
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |=> rsp.valid)
      else $error("response dropped while stalled");
   a_idle_task: assert property (@(posedge clock) disable iff (reset)
      !cur_valid_ff |-> cur_task_ff == '0)
      else $error("idle scheduler holds a task index");

endmodule
